[src/twrm_pkg.sv]
package twrm_pkg;

   localparam int RULE_SLOTS_DEFAULT = 16;

   localparam int MINUTE_W = 11;
   localparam int DAY_W    = 3;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [DAY_W-1:0] ANY_WEEKDAY = 3'd7;

   typedef struct packed {
      logic [1:0]          command;
      logic [MINUTE_W-1:0] rule_begin;
      logic [MINUTE_W-1:0] rule_end;
      logic [DAY_W-1:0]    rule_day;
      logic                rule_inverted;
      logic [MINUTE_W-1:0] query_minute;
      logic [DAY_W-1:0]    query_day;
   } req_type;

   typedef struct packed {
      logic matched;
      logic permitted;
      logic plain_rule_seen;
      logic insert_refused;
   } rsp_type;

   // One stored rule as it sits in the rule memory.
   typedef struct packed {
      logic [MINUTE_W-1:0] start;
      logic [MINUTE_W-1:0] stop;
      logic [DAY_W-1:0]    weekday;
      logic                negated;
   } rule_type;

   typedef struct packed {
      logic latch;
      logic decode;
      logic scan;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic is_query;
      logic count_zero;
      logic scan_done;
   } dp_status_type;

endpackage

[src/twrm_ram.sv]
module twrm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                     rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/twrm_dp.sv]
module twrm_dp
   import twrm_pkg::*;
#(
   parameter int RuleSlots = RULE_SLOTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  req_type       req_data,
   output rsp_type       rsp_data
);

   localparam int CNT_W = $clog2(RuleSlots + 1);
   localparam int IDX_W = (RuleSlots > 1) ? $clog2(RuleSlots) : 1;
   localparam int RULE_W = $bits(rule_type);

   req_type           item_ff,      item_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   logic [IDX_W-1:0]  rd_idx_ff,    rd_idx_in;
   logic [CNT_W-1:0]  rd_left_ff,   rd_left_in;
   logic              chk_valid_ff, chk_valid_in;
   logic              hit_ff,       hit_in;
   logic              allow_ff,     allow_in;
   logic              plain_ff,     plain_in;
   logic              refused_ff,   refused_in;
   rsp_type           rsp_ff,       rsp_in;

   logic              full;
   logic              wr_en;
   logic              rd_en;
   logic [RULE_W-1:0] rd_word;
   rule_type          rule;
   logic              contains;
   logic              stop_now;

   assign full = (count_ff >= CNT_W'(RuleSlots));
   assign wr_en = cmd.decode && (item_ff.command == CMD_INSERT) && !full;

   assign rule = rule_type'(rd_word);
   assign contains = (item_ff.query_minute >= rule.start) &&
                     (item_ff.query_minute <= rule.stop) &&
                     ((rule.weekday == ANY_WEEKDAY) || (rule.weekday == item_ff.query_day));

   // The scan ends on the first containing rule or once the oldest rule is checked.
   assign stop_now = chk_valid_ff && (contains || (rd_left_ff == '0));
   assign rd_en    = cmd.scan && (rd_left_ff != '0) && !stop_now;

   twrm_ram #(
      .Width (RULE_W),
      .Depth (RuleSlots)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (RULE_W'({item_ff.rule_begin, item_ff.rule_end,
                         item_ff.rule_day, item_ff.rule_inverted})),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_word)
   );

   always_comb begin
      item_in      = cmd.latch ? req_data : item_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      rd_left_in   = rd_left_ff;
      chk_valid_in = 1'b0;
      hit_in       = hit_ff;
      allow_in     = allow_ff;
      plain_in     = plain_ff;
      refused_in   = refused_ff;
      rsp_in       = rsp_ff;

      if (cmd.decode) begin
         hit_in     = 1'b0;
         allow_in   = 1'b0;
         plain_in   = 1'b0;
         refused_in = (item_ff.command == CMD_INSERT) && full;
         rd_left_in = count_ff;
         rd_idx_in  = IDX_W'(count_ff - 1'b1);
         if (wr_en) begin
            count_in = count_ff + 1'b1;
         end else if (item_ff.command == CMD_CLEAR) begin
            count_in = '0;
         end
      end

      if (cmd.scan) begin
         chk_valid_in = rd_en;
         if (rd_en) begin
            rd_idx_in  = rd_idx_ff - 1'b1;
            rd_left_in = rd_left_ff - 1'b1;
         end
         if (chk_valid_ff) begin
            if (!rule.negated) begin
               plain_in = 1'b1;
            end
            if (contains) begin
               hit_in   = 1'b1;
               allow_in = !rule.negated;
            end
         end
      end

      if (cmd.finish) begin
         rsp_in = '{matched:         hit_ff,
                    permitted:       allow_ff,
                    plain_rule_seen: plain_ff,
                    insert_refused:  refused_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
      end
      item_ff    <= item_in;
      rd_idx_ff  <= rd_idx_in;
      rd_left_ff <= rd_left_in;
      hit_ff     <= hit_in;
      allow_ff   <= allow_in;
      plain_ff   <= plain_in;
      refused_ff <= refused_in;
      rsp_ff     <= rsp_in;
   end

   assign status.is_query   = (item_ff.command == CMD_QUERY);
   assign status.count_zero = (count_ff == '0);
   assign status.scan_done  = stop_now;
   assign rsp_data          = rsp_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RuleSlots))
      else $error("rule count beyond the table size");

   a_refuse_only_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && refused_ff) |-> (count_ff == CNT_W'(RuleSlots)))
      else $error("insert refused while the table had room");

   a_check_follows_read: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> $past(rd_en))
      else $error("rule checked without a preceding read");

endmodule

[src/twrm_ctrl.sv]
module twrm_ctrl
   import twrm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   // The result register may be refilled in the cycle its previous transfer completes.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   assign cmd.latch  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.decode = (state_ff == ST_DECODE);
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.finish = (state_ff == ST_FINISH) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_FINISH) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               if (status.is_query && !status.count_zero) begin
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

endmodule

[src/time_window_rule_match.sv]
// An insert, clear or unused command raises rsp_valid after the decode and finish steps;
// a query also passes through the scan step, which checks 1 to RuleSlots rules, unless
// the table is empty. The scan reads one rule per cycle through the registered
// port of the rule memory. A result still waiting for its transfer holds the finish step.
// A new item is accepted the cycle after the result register is loaded.
// Synchronous active-high reset empties the table; rule storage itself is not cleared.
module time_window_rule_match
   import twrm_pkg::*;
#(
   parameter int RuleSlots = RULE_SLOTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   twrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   twrm_dp #(
      .RuleSlots (RuleSlots)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import twrm_pkg::*;

   localparam int         RULE_SLOTS   = RULE_SLOTS_DEFAULT;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 1000;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         FLUSH_CYCLES = 40;

   typedef struct {
      req_type item;
      bit      drain;
   } stim_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_type pending_requests[$];
   rsp_type  awaited_verdicts[$];

   // Shadow copy of the rule table, slot model_count-1 being the newest rule.
   logic [MINUTE_W-1:0] model_start   [RULE_SLOTS];
   logic [MINUTE_W-1:0] model_stop    [RULE_SLOTS];
   logic [DAY_W-1:0]    model_weekday [RULE_SLOTS];
   logic                model_negated [RULE_SLOTS];
   int                  model_count = 0;

   int errors      = 0;
   int accepted    = 0;
   int results     = 0;
   int idle_cycles = 0;
   int total_items = 0;
   int n_queries   = 0;
   int n_hits      = 0;
   int n_refused   = 0;
   int n_clears    = 0;

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int send_gap  = 0;
   int recv_wait = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;

   time_window_rule_match #(
      .RuleSlots (RULE_SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic rsp_type match_rules(req_type r);
      rsp_type v;
      int      k;
      v = '0;
      case (r.command)
         CMD_INSERT: begin
            if (model_count >= RULE_SLOTS) begin
               v.insert_refused = 1'b1;
               n_refused++;
            end else begin
               model_start[model_count]   = r.rule_begin;
               model_stop[model_count]    = r.rule_end;
               model_weekday[model_count] = r.rule_day;
               model_negated[model_count] = r.rule_inverted;
               model_count++;
            end
         end
         CMD_QUERY: begin
            n_queries++;
            k = model_count;
            while (k > 0 && !v.matched) begin
               k--;
               if (!model_negated[k]) v.plain_rule_seen = 1'b1;
               if (r.query_minute >= model_start[k] && r.query_minute <= model_stop[k] &&
                   (model_weekday[k] == ANY_WEEKDAY || model_weekday[k] == r.query_day)) begin
                  v.matched   = 1'b1;
                  v.permitted = !model_negated[k];
               end
            end
            if (v.matched) n_hits++;
         end
         CMD_CLEAR: begin
            model_count = 0;
            n_clears++;
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
   endtask

   task automatic compare_bit(string name, logic got, logic want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d: %s is %b, expected %b", results, name, got,
                                   want));
      end
   endtask

   // Quiet stretches with no idling come from flipping the calm mark now and then.
   function automatic int next_gap(inout bit calm);
      if ($urandom_range(0, 29) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 19));
   endfunction

   task automatic push_request(req_type r, bit drain = 1'b0);
      stim_type s;
      s.item  = r;
      s.drain = drain;
      pending_requests.push_back(s);
   endtask

   function automatic req_type make_rule(logic [MINUTE_W-1:0] lo, logic [MINUTE_W-1:0] hi,
                                         logic [DAY_W-1:0] day, logic inv);
      req_type r;
      r               = '0;
      r.command       = CMD_INSERT;
      r.rule_begin    = lo;
      r.rule_end      = hi;
      r.rule_day      = day;
      r.rule_inverted = inv;
      return r;
   endfunction

   function automatic req_type make_query(logic [MINUTE_W-1:0] minute, logic [DAY_W-1:0] day);
      req_type r;
      r              = '0;
      r.command      = CMD_QUERY;
      r.query_minute = minute;
      r.query_day    = day;
      return r;
   endfunction

   function automatic req_type random_fields();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   task automatic add_directed_requests();
      req_type r;
      int      i;
      push_request(make_query(11'd0, 3'd0));
      r         = '1;
      r.command = CMD_UNUSED;
      push_request(r);
      // Oldest rule covers the whole day, then an empty window and an out-of-range one.
      push_request(make_rule(11'd0, 11'd1439, ANY_WEEKDAY, 1'b0));
      push_request(make_rule(11'd1439, 11'd0, ANY_WEEKDAY, 1'b1));
      push_request(make_rule(11'd2047, 11'd2047, 3'd5, 1'b1));
      push_request(make_rule(11'd600, 11'd700, 3'd2, 1'b1));
      for (i = 0; i < RULE_SLOTS - 5; i++) begin
         push_request(make_rule(MINUTE_W'(1000 + i), MINUTE_W'(1000 + i), DAY_W'(i % 8),
                                1'(i % 2)));
      end
      push_request(make_rule(11'd100, 11'd100, 3'd0, 1'b0));
      r         = '1;
      r.command = CMD_INSERT;
      push_request(r);
      push_request(make_query(11'd650, 3'd2));
      push_request(make_query(11'd2047, 3'd7));
      push_request(make_query(11'd0, 3'd6));
      push_request(make_query(11'd100, 3'd0));
      push_request(make_query(11'd1439, 3'd6));
      r         = '1;
      r.command = CMD_CLEAR;
      push_request(r, 1'b1);
      push_request(make_query(11'd100, 3'd0));
      push_request(make_rule(11'd0, 11'd1439, ANY_WEEKDAY, 1'b1));
      push_request(make_query(11'd5, 3'd1));
   endtask

   task automatic add_random_requests(int count);
      req_type r;
      int      made;
      int      n_ins;
      int      n_qry;
      int      i;
      int      stop;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 2) == 0) begin
            r         = random_fields();
            r.command = CMD_CLEAR;
            push_request(r, $urandom_range(0, 9) == 0);
            made++;
         end
         n_ins = ($urandom_range(0, 6) == 0) ? int'($urandom_range(14, 20))
                                             : int'($urandom_range(1, 5));
         n_qry = int'($urandom_range(1, 8));
         for (i = 0; i < n_ins + n_qry; i++) begin
            r = random_fields();
            if (i < n_ins || $urandom_range(0, 9) == 0) begin
               r.command    = CMD_INSERT;
               r.rule_begin = MINUTE_W'($urandom_range(0, 1439));
               case ($urandom_range(0, 9))
                  0: r.rule_end = MINUTE_W'($urandom_range(0, int'(r.rule_begin)));
                  1: begin
                     r.rule_begin = MINUTE_W'($urandom_range(0, 2047));
                     r.rule_end   = MINUTE_W'($urandom_range(0, 2047));
                  end
                  default: begin
                     stop       = int'(r.rule_begin) + int'($urandom_range(0, 700));
                     r.rule_end = MINUTE_W'((stop > 1439) ? 1439 : stop);
                  end
               endcase
               r.rule_day      = ($urandom_range(0, 2) == 0) ? ANY_WEEKDAY
                                                             : DAY_W'($urandom_range(0, 7));
               r.rule_inverted = ($urandom_range(0, 2) == 0);
            end else begin
               r.command      = CMD_QUERY;
               r.query_minute = ($urandom_range(0, 9) == 0) ? MINUTE_W'($urandom_range(0, 2047))
                                                            : MINUTE_W'($urandom_range(0, 1439));
               r.query_day    = ($urandom_range(0, 19) == 0) ? 3'd7
                                                             : DAY_W'($urandom_range(0, 6));
            end
            push_request(r, $urandom_range(0, 149) == 0);
            made++;
         end
         if ($urandom_range(0, 15) == 0) begin
            r         = random_fields();
            r.command = CMD_UNUSED;
            push_request(r);
         end
      end
   endtask

   // Checks and predictions are taken at the rising edge, before the block updates.
   always @(posedge clock) begin
      rsp_type want;
      req_taken = !reset && req_valid && req_ready;
      rsp_taken = !reset && rsp_valid && rsp_ready;
      if (rsp_taken) begin
         if (awaited_verdicts.size() == 0) begin
            report_mismatch($sformatf("result %b arrived with nothing outstanding", rsp_data));
         end else begin
            want = awaited_verdicts.pop_front();
            compare_bit("matched", rsp_data.matched, want.matched);
            compare_bit("permitted", rsp_data.permitted, want.permitted);
            compare_bit("plain_rule_seen", rsp_data.plain_rule_seen, want.plain_rule_seen);
            compare_bit("insert_refused", rsp_data.insert_refused, want.insert_refused);
         end
         results++;
      end
      if (req_taken) begin
         awaited_verdicts.push_back(match_rules(req_data));
         accepted++;
      end
      idle_cycles = (req_taken || rsp_taken || reset) ? 0 : idle_cycles + 1;
   end

   // A request flagged for draining is held back until every outstanding result is in.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain && awaited_verdicts.size() != 0)) begin
            req_data  <= pending_requests[0].item;
            req_valid <= 1'b1;
            void'(pending_requests.pop_front());
            send_gap  <= next_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) recv_wait = next_gap(recv_calm);
         if (recv_wait > 0 && rsp_valid) recv_wait--;
         rsp_ready <= (recv_wait == 0);
      end
   end

   always @(negedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("No transfer for %0d cycles, giving up.", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      add_directed_requests();
      add_random_requests(RANDOM_ITEMS);
      total_items = pending_requests.size();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (accepted < total_items || awaited_verdicts.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
      $display("Checked %0d results from %0d requests: %0d queries, %0d of them matched.",
               results, accepted, n_queries, n_hits);
      $display("Table cleared %0d times, %0d inserts turned away on a full table.",
               n_clears, n_refused);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
src/twrm_pkg.sv
src/twrm_ram.sv
src/twrm_dp.sv
src/twrm_ctrl.sv
src/time_window_rule_match.sv
tb/testbench.sv
